### src/tmr_pkg.sv
package tmr_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int TID_W     = 4;
    localparam int DELAY_W   = 16;
    localparam int TIME_W    = 32;
    // Wide enough to hold any task id and the slot count itself.
    localparam int ID_EXT_W  = ((IDX_W > TID_W) ? IDX_W : TID_W) + 1;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_ONESHOT  = 2'd1,
        KIND_PERIODIC = 2'd2,
        KIND_CANCEL   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_TICK,
        ST_RD,
        ST_CMP,
        ST_UPD,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [DELAY_W-1:0] period;
        logic [TIME_W-1:0]  due;
    } slot_word_t;

    // Requests from the sequencer to the output stage.
    typedef struct packed {
        logic             fire;
        logic             flush;
        logic [TID_W-1:0] id;
    } out_ev_t;

endpackage

### src/tmr_ram.sv
module tmr_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/tmr_alu.sv
module tmr_alu import tmr_pkg::*; (
    input  logic [TIME_W-1:0] a,
    input  logic [TIME_W-1:0] b,
    input  logic              sub,
    output logic [TIME_W-1:0] y
);

    assign y = sub ? (a - b) : (a + b);

endmodule

### src/tmr_seq.sv
module tmr_seq import tmr_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  kind_t              in_kind,
    input  logic [TID_W-1:0]   in_id,
    input  logic [DELAY_W-1:0] in_delay,
    output out_ev_t            ev,
    input  logic               ev_ready
);

    state_t               state_reg, state_next;
    kind_t                kind_reg;
    logic [ID_EXT_W-1:0]  id_reg;
    logic [DELAY_W-1:0]   delay_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [NUM_SLOTS-1:0] live_reg;
    logic [NUM_SLOTS-1:0] per_reg;
    logic [IDX_W-1:0]     idx_reg;

    logic [IDX_W-1:0]  cmd_idx;
    logic              id_ok;
    logic              idx_last;
    logic              due_now;

    logic [TIME_W-1:0] alu_a, alu_b, alu_y;
    logic              alu_sub;

    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr;
    slot_word_t        ram_wdata, ram_rdata;

    assign cmd_idx  = id_reg[IDX_W-1:0];
    assign id_ok    = id_reg < ID_EXT_W'(NUM_SLOTS);
    assign idx_last = idx_reg == IDX_W'(NUM_SLOTS - 1);
    // In the compare state the adder yields now minus due; a clear sign bit means due.
    assign due_now  = !alu_y[TIME_W-1];

    tmr_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y)
    );

    tmr_ram #(
        .DEPTH (NUM_SLOTS),
        .WIDTH ($bits(slot_word_t))
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = (in_kind == KIND_TICK) ? ST_TICK : ST_CMD;
                end
            end
            ST_CMD:  state_next = ST_IDLE;
            ST_TICK: state_next = ST_RD;
            ST_RD: begin
                if (live_reg[idx_reg]) begin
                    state_next = ST_CMP;
                end else if (idx_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_CMP: begin
                if (!due_now || (ev_ready && !per_reg[idx_reg])) begin
                    state_next = idx_last ? ST_FLUSH : ST_RD;
                end else if (ev_ready) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:  state_next = idx_last ? ST_FLUSH : ST_RD;
            ST_FLUSH: begin
                if (ev_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        alu_a     = now_reg;
        alu_b     = '0;
        alu_sub   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '{period: delay_reg, due: alu_y};
        ev        = '{fire: 1'b0, flush: 1'b0, id: TID_W'(idx_reg)};
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_CMD: begin
                alu_b     = TIME_W'(delay_reg);
                ram_waddr = cmd_idx;
                ram_we    = id_ok && (kind_reg != KIND_CANCEL) && !live_reg[cmd_idx];
            end
            ST_TICK: alu_b = TIME_W'(1);
            ST_RD:   ram_re = live_reg[idx_reg];
            ST_CMP: begin
                alu_b   = ram_rdata.due;
                alu_sub = 1'b1;
                ev.fire = due_now;
            end
            ST_UPD: begin
                alu_a     = ram_rdata.due;
                alu_b     = TIME_W'(ram_rdata.period);
                ram_we    = 1'b1;
                ram_wdata = '{period: ram_rdata.period, due: alu_y};
            end
            ST_FLUSH: ev.flush = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            now_reg   <= '0;
            live_reg  <= '0;
            per_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        kind_reg  <= in_kind;
                        id_reg    <= ID_EXT_W'(in_id);
                        delay_reg <= in_delay;
                    end
                end
                ST_CMD: begin
                    if (id_ok) begin
                        if (kind_reg == KIND_CANCEL) begin
                            live_reg[cmd_idx] <= 1'b0;
                        end else if (!live_reg[cmd_idx]) begin
                            live_reg[cmd_idx] <= 1'b1;
                            per_reg[cmd_idx]  <= (kind_reg == KIND_PERIODIC);
                        end
                    end
                end
                ST_TICK: begin
                    now_reg <= alu_y;
                    idx_reg <= '0;
                end
                ST_RD: begin
                    if (!live_reg[idx_reg]) begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_CMP: begin
                    if (!due_now || ev_ready) begin
                        if (due_now && !per_reg[idx_reg]) begin
                            live_reg[idx_reg] <= 1'b0;
                        end
                        // A periodic firing moves on after its due time is rewritten.
                        if (!(due_now && per_reg[idx_reg])) begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end
                end
                ST_UPD:  idx_reg <= idx_reg + IDX_W'(1);
                ST_FLUSH: ;
                default: ;
            endcase
        end
    end

endmodule

### src/tmr_out.sv
module tmr_out import tmr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  out_ev_t              ev,
    output logic                 ev_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    // A firing is held back until the next one or the end of the scan shows
    // whether it is the last of its tick.
    logic             pend_valid_reg;
    logic [TID_W-1:0] pend_id_reg;
    logic             out_valid_reg;
    logic [TID_W-1:0] out_id_reg;
    logic             out_last_reg;

    logic out_free;
    logic load;

    assign out_free = !out_valid_reg || m_tready;
    assign ev_ready = !pend_valid_reg || out_free;
    assign load     = (ev.fire || ev.flush) && pend_valid_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                out_id_reg    <= pend_id_reg;
                out_last_reg  <= ev.flush;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (ev.fire && ev_ready) begin
                pend_valid_reg <= 1'b1;
                pend_id_reg    <= ev.id;
            end else if (ev.flush && ev_ready) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_id_reg);
    assign m_tlast  = out_last_reg;

endmodule

### src/periodic_and_oneshot_timer_table_top.sv
// Timer table with one slot per task id.
// Input channel s_*: an item is a tick, a one-shot start, a periodic start or a
// cancel, chosen by s_tuser. A start arms a free slot to fire delay ticks from now
// (a periodic slot then repeats with that period); a cancel frees the slot.
// Output channel m_*: one item per firing, giving the slot id; m_tlast marks the
// last firing of a tick. A tick with nothing due produces no item.
// Sequence: a start or cancel passes through the command state back to idle. A
// tick advances the time counter, then scans the slots: a free slot is skipped, a
// live slot is read and compared, and a due periodic slot has its due rewritten;
// a flush step closes the run. The scan is paced by the single shared 32-bit adder
// that does every add and compare on times, and by a slot memory read for each live slot.
// s_tready is high only between items.
// Reset clears the time counter and every slot; no clearing pass is needed.
// A stalled receiver holds the output register; once the next firing is waiting
// behind it, the scan pauses at the next due slot or the flush step until m_tready returns.
module periodic_and_oneshot_timer_table_top import tmr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [3:0] task_id, [19:4] delay, [23:20] zero
    input  logic [S_TUSER_W-1:0] s_tuser,  // [1:0] kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [3:0] fired_task, [7:4] zero
    output logic                 m_tlast   // last_fired
);

    out_ev_t ev;
    logic    ev_ready;

    tmr_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (kind_t'(s_tuser)),
        .in_id    (s_tdata[TID_W-1:0]),
        .in_delay (s_tdata[TID_W+DELAY_W-1:TID_W]),
        .ev       (ev),
        .ev_ready (ev_ready)
    );

    tmr_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ev       (ev),
        .ev_ready (ev_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### src/tmr_checker.sv
module tmr_checker import tmr_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Input ready drops once an item is accepted: the block leaves idle for the command or tick state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after an item");

    // No new result appears while the block waits for an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared while idle");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind periodic_and_oneshot_timer_table_top tmr_checker u_chk (.*);

### dv/periodic_and_oneshot_timer_table_top_tb.sv
module periodic_and_oneshot_timer_table_top_tb;
    import tmr_pkg::*;

    typedef struct {
        kind_t              kind;
        logic [TID_W-1:0]   task_id;
        logic [DELAY_W-1:0] delay;
        int                 gap;
        bit                 drain;
    } timer_cmd_t;

    typedef struct {
        logic [TID_W-1:0] task_id;
        logic             last;
    } firing_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // Predicted timer table.
    logic               tbl_live     [NUM_SLOTS];
    logic               tbl_periodic [NUM_SLOTS];
    logic [TIME_W-1:0]  tbl_due      [NUM_SLOTS];
    logic [DELAY_W-1:0] tbl_period   [NUM_SLOTS];
    logic [TIME_W-1:0]  tbl_now;

    timer_cmd_t cmd_queue [$];
    firing_t    firings_due [$];
    firing_t    mon_exp;

    int  err_count = 0;
    int  in_count  = 0;
    int  res_count = 0;
    int  gen_count = 0;
    bit  tx_calm   = 1'b0;

    int  drv_taken = 0;
    bit  drv_busy  = 1'b0;
    int  drv_gap   = 0;

    int  rx_seen   = 0;
    int  rx_wait   = 0;
    int  rx_hold   = 0;
    bit  rx_calm   = 1'b0;

    periodic_and_oneshot_timer_table_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Updates the predicted table for one accepted item and queues the firings it causes.
    task automatic apply_timer_item(kind_t kind, logic [TID_W-1:0] id, logic [DELAY_W-1:0] delay);
        int          hits [$];
        logic [TIME_W-1:0] diff;
        firing_t     f;
        if (kind == KIND_TICK) begin
            tbl_now = tbl_now + 1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                diff = tbl_now - tbl_due[i];
                if (tbl_live[i] && !diff[TIME_W-1]) begin
                    hits.push_back(i);
                    if (tbl_periodic[i])
                        tbl_due[i] = tbl_due[i] + TIME_W'(tbl_period[i]);
                    else
                        tbl_live[i] = 1'b0;
                end
            end
            foreach (hits[j]) begin
                f.task_id = hits[j][TID_W-1:0];
                f.last    = (j == hits.size() - 1);
                firings_due.push_back(f);
            end
        end else if (int'(id) < NUM_SLOTS) begin
            if (kind == KIND_CANCEL) begin
                tbl_live[id] = 1'b0;
            end else if (!tbl_live[id]) begin
                tbl_live[id]     = 1'b1;
                tbl_periodic[id] = (kind == KIND_PERIODIC);
                tbl_due[id]      = tbl_now + TIME_W'(delay);
                tbl_period[id]   = delay;
            end
        end
    endtask

    task automatic queue_cmd(kind_t kind, int id, int delay, bit drain);
        timer_cmd_t c;
        c.kind    = kind;
        c.task_id = id[TID_W-1:0];
        c.delay   = delay[DELAY_W-1:0];
        c.gap     = tx_calm ? 0 : $urandom_range(0, 12);
        c.drain   = drain;
        cmd_queue.push_back(c);
        gen_count++;
    endtask

    // Mostly short delays so that slots fire within a few ticks.
    function automatic int pick_delay();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 65535);
        return $urandom_range(0, 6);
    endfunction

    function automatic kind_t pick_start();
        return $urandom_range(0, 1) ? KIND_PERIODIC : KIND_ONESHOT;
    endfunction

    task automatic queue_tick();
        queue_cmd(KIND_TICK, $urandom_range(0, 15), $urandom_range(0, 65535), 1'b0);
    endtask

    always @(negedge aclk) begin
        timer_cmd_t nxt;
        logic       v;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            v = s_tvalid;
            if (drv_busy && in_count != drv_taken) begin
                drv_taken = in_count;
                drv_busy  = 1'b0;
                v         = 1'b0;
            end
            if (!drv_busy) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (cmd_queue.size() > 0 &&
                             !(cmd_queue[0].drain && firings_due.size() != 0)) begin
                    nxt = cmd_queue.pop_front();
                    s_tdata  <= {{(S_TDATA_W-DELAY_W-TID_W){1'b0}}, nxt.delay, nxt.task_id};
                    s_tuser  <= nxt.kind;
                    drv_gap  = nxt.gap;
                    drv_busy = 1'b1;
                    v        = 1'b1;
                end
            end
            s_tvalid <= v;
        end
    end

    always @(negedge aclk) begin
        logic rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_seen != res_count) begin
                rx_seen = res_count;
                if ($urandom_range(0, 31) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 12);
                // One long hold-off so that the block backs up and stalls its input.
                if (res_count == 60)
                    rx_hold = 300;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                rdy = 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                res_count <= res_count + 1;
                if (firings_due.size() == 0) begin
                    $display("%0t unexpected firing: expected none, actual task %0d last %0b",
                             $time, m_tdata[TID_W-1:0], m_tlast);
                    err_count++;
                end else begin
                    mon_exp = firings_due.pop_front();
                    if (m_tdata[TID_W-1:0] !== mon_exp.task_id) begin
                        $display("%0t fired_task mismatch: expected %0d, actual %0d",
                                 $time, mon_exp.task_id, m_tdata[TID_W-1:0]);
                        err_count++;
                    end
                    if (m_tlast !== mon_exp.last) begin
                        $display("%0t last_fired mismatch: expected %0b, actual %0b",
                                 $time, mon_exp.last, m_tlast);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                in_count <= in_count + 1;
                apply_timer_item(kind_t'(s_tuser), s_tdata[TID_W-1:0],
                                 s_tdata[TID_W +: DELAY_W]);
            end
        end
    end

    initial begin
        int target;
        int k;
        bit drain;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tbl_live[i]     = 1'b0;
            tbl_periodic[i] = 1'b0;
            tbl_due[i]      = '0;
            tbl_period[i]   = '0;
        end
        tbl_now = '0;

        // Directed part: zero delay, zero period, restart of a live slot,
        // cancel of a free slot and the largest delay.
        queue_cmd(KIND_ONESHOT, 0, 0, 1'b0);
        queue_cmd(KIND_PERIODIC, 15, 0, 1'b0);
        queue_tick();
        queue_tick();
        queue_cmd(KIND_ONESHOT, 15, 9, 1'b0);
        queue_tick();
        queue_cmd(KIND_CANCEL, 3, 0, 1'b0);
        queue_cmd(KIND_CANCEL, 15, 16'hffff, 1'b0);
        queue_tick();
        queue_cmd(KIND_ONESHOT, 7, 16'hffff, 1'b0);
        queue_cmd(KIND_PERIODIC, 8, 3, 1'b0);
        queue_cmd(KIND_ONESHOT, 1, 16'h5555, 1'b0);
        queue_cmd(KIND_PERIODIC, 2, 16'haaaa, 1'b0);
        repeat (4) queue_tick();
        queue_cmd(KIND_CANCEL, 7, 0, 1'b0);
        queue_cmd(KIND_CANCEL, 8, 0, 1'b0);
        queue_cmd(KIND_CANCEL, 1, 0, 1'b0);
        queue_cmd(KIND_CANCEL, 2, 0, 1'b0);
        queue_cmd(KIND_PERIODIC, 4, 1, 1'b1);
        repeat (3) queue_tick();
        queue_cmd(KIND_CANCEL, 4, 0, 1'b0);

        target = gen_count + 440;
        while (gen_count < target) begin
            if ($urandom_range(0, 7) == 0)
                tx_calm = !tx_calm;
            drain = ($urandom_range(0, 15) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    // Whole table armed at once, so that one tick can fire every slot.
                    for (int i = 0; i < NUM_SLOTS; i++)
                        queue_cmd(pick_start(), i, $urandom_range(0, 2), drain && i == 0);
                    repeat (3) queue_tick();
                    for (int i = 0; i < NUM_SLOTS; i++)
                        queue_cmd(KIND_CANCEL, i, $urandom_range(0, 65535), 1'b0);
                end
                1, 2, 3: begin
                    k = $urandom_range(1, 6);
                    for (int i = 0; i < k; i++)
                        queue_cmd(kind_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                                  $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 8),
                                  drain && i == 0);
                end
                default: begin
                    k = $urandom_range(1, 5);
                    for (int i = 0; i < k; i++)
                        queue_cmd(pick_start(), $urandom_range(0, 15), pick_delay(),
                                  drain && i == 0);
                    repeat ($urandom_range(1, 8)) queue_tick();
                    if ($urandom_range(0, 1))
                        queue_cmd(KIND_CANCEL, $urandom_range(0, 15), 0, 1'b0);
                end
            endcase
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (cmd_queue.size() != 0 || drv_busy || firings_due.size() != 0)
            @(posedge aclk);
        repeat (3 * NUM_SLOTS + 8) @(posedge aclk);

        if (firings_due.size() != 0) begin
            $display("%0t missing firings: expected %0d more, actual 0",
                     $time, firings_due.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
src/tmr_pkg.sv
src/tmr_ram.sv
src/tmr_alu.sv
src/tmr_seq.sv
src/tmr_out.sv
src/periodic_and_oneshot_timer_table_top.sv
src/tmr_checker.sv
dv/periodic_and_oneshot_timer_table_top_tb.sv
